// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the design folder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge, off while reset is low.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Plain invariant checked on every rising clock edge, off while reset is low.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

`endif

// ===== design/lei_pkg.sv =====
// ----------------------------------------------------------------------------
// lei_pkg
// Types and constants shared by the line edit input unit.
// ----------------------------------------------------------------------------
package lei_pkg;

    localparam int DATA_W      = 32;
    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 80;

    // input item selector
    localparam logic MODE_REQUEST = 1'b0;
    localparam logic MODE_CHAR    = 1'b1;

    // register indexes (paddr[2])
    localparam logic REG_WINDOW_START = 1'b0;
    localparam logic REG_WINDOW_END   = 1'b1;

    localparam logic [DATA_W-1:0] WINDOW_START_RST = 32'hA000_0000;
    localparam logic [DATA_W-1:0] WINDOW_END_RST   = 32'hA3FF_FFFF;

    // character codes
    localparam logic [7:0] CH_EOT   = 8'd4;
    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_DEL   = 8'd127;

    typedef enum logic [1:0] {
        KIND_ECHO   = 2'd0,
        KIND_STORE  = 2'd1,
        KIND_FINISH = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_DESC = 2'd1,
        ST_BAD_ADDR = 2'd2
    } t_status;

    // classified work passed from front to back
    typedef enum logic [1:0] {
        OP_FINISH  = 2'd0,  // one finish result
        OP_ERASE   = 2'd1,  // echo BS, SP, BS
        OP_NEWLINE = 2'd2,  // store LF, echo LF, finish
        OP_CHAR    = 2'd3   // echo, store, optional finish
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [7:0]         ch;
        logic [DATA_W-1:0]  offset;
        t_status            status;
        logic               fin;
        logic [DATA_W-1:0]  count;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

endpackage

// ===== design/lei_fifo.sv =====
// ----------------------------------------------------------------------------
// lei_fifo
// Short command queue between the classifier and the result sequencer.
// ----------------------------------------------------------------------------
module lei_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  lei_pkg::t_cmd       i_data,
    input  logic                i_pop,
    output lei_pkg::t_cmd       o_data,
    output lei_pkg::t_fifo_stat o_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    lei_pkg::t_cmd    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_cnt == CNT_W'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);

endmodule

// ===== design/lei_front.sv =====
// ----------------------------------------------------------------------------
// lei_front
// Accepts items, keeps session state, classifies each item that produces output into a command.
// ----------------------------------------------------------------------------
module lei_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic                         i_mode,
    input  logic [7:0]                   i_descriptor,
    input  logic [lei_pkg::DATA_W-1:0]   i_buffer_address,
    input  logic [lei_pkg::DATA_W-1:0]   i_length,
    input  logic [7:0]                   i_char_in,
    input  logic [lei_pkg::DATA_W-1:0]   i_window_start,
    input  logic [lei_pkg::DATA_W-1:0]   i_window_end,
    input  lei_pkg::t_fifo_stat          i_fifo_stat,
    output logic                         o_ready,
    output logic                         o_push,
    output lei_pkg::t_cmd                o_cmd
);

    logic                        r_open, n_open;
    logic [lei_pkg::DATA_W-1:0]  r_fill, n_fill;
    logic [lei_pkg::DATA_W-1:0]  r_len, n_len;

    logic                        accept;
    logic                        has_cmd;
    logic [lei_pkg::DATA_W:0]    range_top;
    logic                        bad_addr;
    logic [lei_pkg::DATA_W-1:0]  fill_inc;

    assign o_ready = !i_fifo_stat.full;
    assign accept  = i_valid && o_ready;

    // last byte of the buffer, 33 bits so it cannot wrap
    assign range_top = {1'b0, i_buffer_address} + {1'b0, i_length} - 1'b1;
    assign bad_addr  = (i_buffer_address < i_window_start) ||
                       ((i_length != '0) && (range_top > {1'b0, i_window_end}));
    assign fill_inc  = r_fill + 1'b1;

    always_comb begin
        n_open       = r_open;
        n_fill       = r_fill;
        n_len        = r_len;
        has_cmd      = 1'b0;
        o_cmd.op     = lei_pkg::OP_FINISH;
        o_cmd.ch     = i_char_in;
        o_cmd.offset = r_fill;
        o_cmd.status = lei_pkg::ST_OK;
        o_cmd.fin    = 1'b0;
        o_cmd.count  = r_fill;
        if (i_mode == lei_pkg::MODE_REQUEST) begin
            n_open      = 1'b0;
            n_fill      = '0;
            n_len       = i_length;
            o_cmd.count = '0;
            if (i_descriptor != 8'd0) begin
                has_cmd      = 1'b1;
                o_cmd.status = lei_pkg::ST_BAD_DESC;
            end else if (bad_addr) begin
                has_cmd      = 1'b1;
                o_cmd.status = lei_pkg::ST_BAD_ADDR;
            end else if (i_length == '0) begin
                has_cmd = 1'b1;
            end else begin
                n_open = 1'b1;
            end
        end else if (r_open) begin
            case (i_char_in) inside
                lei_pkg::CH_EOT: begin
                    has_cmd = 1'b1;
                    n_open  = 1'b0;
                end
                lei_pkg::CH_BS, lei_pkg::CH_DEL: begin
                    if (r_fill != '0) begin
                        has_cmd  = 1'b1;
                        o_cmd.op = lei_pkg::OP_ERASE;
                        n_fill   = r_fill - 1'b1;
                    end
                end
                lei_pkg::CH_LF, lei_pkg::CH_CR: begin
                    has_cmd  = 1'b1;
                    o_cmd.op = lei_pkg::OP_NEWLINE;
                    n_open   = 1'b0;
                end
                default: begin
                    has_cmd     = 1'b1;
                    o_cmd.op    = lei_pkg::OP_CHAR;
                    o_cmd.count = fill_inc;
                    n_fill      = fill_inc;
                    if (fill_inc == r_len) begin
                        o_cmd.fin = 1'b1;
                        n_open    = 1'b0;
                    end
                end
            endcase
        end
    end

    assign o_push = accept && has_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_fill <= '0;
            r_len  <= '0;
        end else if (accept) begin
            r_open <= n_open;
            r_fill <= n_fill;
            r_len  <= n_len;
        end
    end

endmodule

// ===== design/lei_back.sv =====
// ----------------------------------------------------------------------------
// lei_back
// Expands queued commands into result transfers through an output register.
// ----------------------------------------------------------------------------
module lei_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lei_pkg::t_cmd                i_cmd,
    input  lei_pkg::t_fifo_stat          i_fifo_stat,
    input  logic                         i_ready,
    output logic                         o_pop,
    output logic                         o_valid,
    output lei_pkg::t_kind               o_kind,
    output logic [7:0]                   o_byte,
    output logic [lei_pkg::DATA_W-1:0]   o_offset,
    output lei_pkg::t_status             o_status,
    output logic [lei_pkg::DATA_W-1:0]   o_count,
    output logic                         o_last
);

    logic [1:0]                  r_step;
    logic                        r_valid;
    lei_pkg::t_kind              r_kind;
    logic [7:0]                  r_byte;
    logic [lei_pkg::DATA_W-1:0]  r_offset;
    lei_pkg::t_status            r_status;
    logic [lei_pkg::DATA_W-1:0]  r_count;
    logic                        r_last;

    logic                        out_free, fire, last_step;
    lei_pkg::t_kind              n_kind;
    logic [7:0]                  n_byte;
    logic [lei_pkg::DATA_W-1:0]  n_offset;
    lei_pkg::t_status            n_status;
    logic [lei_pkg::DATA_W-1:0]  n_count;

    assign out_free = !r_valid || i_ready;
    assign fire     = out_free && !i_fifo_stat.empty;
    assign o_pop    = fire && last_step;

    always_comb begin
        n_kind    = lei_pkg::KIND_ECHO;
        n_byte    = '0;
        n_offset  = '0;
        n_status  = lei_pkg::ST_OK;
        n_count   = '0;
        last_step = 1'b0;
        unique case (i_cmd.op)
            lei_pkg::OP_FINISH: begin
                n_kind    = lei_pkg::KIND_FINISH;
                n_status  = i_cmd.status;
                n_count   = i_cmd.count;
                last_step = 1'b1;
            end
            lei_pkg::OP_ERASE: begin
                n_byte    = (r_step == 2'd1) ? lei_pkg::CH_SPACE : lei_pkg::CH_BS;
                last_step = (r_step == 2'd2);
            end
            lei_pkg::OP_NEWLINE: begin
                last_step = (r_step == 2'd2);
                if (r_step == 2'd0) begin
                    n_kind   = lei_pkg::KIND_STORE;
                    n_byte   = lei_pkg::CH_LF;
                    n_offset = i_cmd.offset;
                end else if (r_step == 2'd1) begin
                    n_byte = lei_pkg::CH_LF;
                end else begin
                    n_kind  = lei_pkg::KIND_FINISH;
                    n_count = i_cmd.count;
                end
            end
            default: begin
                // plain character
                last_step = i_cmd.fin ? (r_step == 2'd2) : (r_step == 2'd1);
                if (r_step == 2'd0) begin
                    n_byte = i_cmd.ch;
                end else if (r_step == 2'd1) begin
                    n_kind   = lei_pkg::KIND_STORE;
                    n_byte   = i_cmd.ch;
                    n_offset = i_cmd.offset;
                end else begin
                    n_kind  = lei_pkg::KIND_FINISH;
                    n_count = i_cmd.count;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= '0;
            r_valid <= 1'b0;
        end else if (out_free) begin
            r_valid <= fire;
            if (fire) begin
                r_step <= last_step ? 2'd0 : r_step + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_kind   <= n_kind;
            r_byte   <= n_byte;
            r_offset <= n_offset;
            r_status <= n_status;
            r_count  <= n_count;
            r_last   <= last_step;
        end
    end

    assign o_valid  = r_valid;
    assign o_kind   = r_kind;
    assign o_byte   = r_byte;
    assign o_offset = r_offset;
    assign o_status = r_status;
    assign o_count  = r_count;
    assign o_last   = r_last;

endmodule

// ===== design/line_edit_input_unit.sv =====
// Path: results pass from the command queue through the output register.
// Throughput: one result transfer per cycle while the receiver is ready; an item gives
//   one to three results (its result count), and items with no result give none.
// Input side: one item per cycle while the command queue has room.
// Reset (i_rst_n low, synchronous): no session, count zero, queue empty, no output,
//   memory window registers back to their default range.
// ----------------------------------------------------------------------------
// line_edit_input_unit
// Canonical line editing for one terminal read request at a time.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module line_edit_input_unit #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input stream
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    input  logic                                 i_s_tuser,  // mode
    // descriptor[7:0], buffer_address[39:8], length[71:40], char_in[79:72]
    input  logic [lei_pkg::IN_TDATA_W-1:0]       i_s_tdata,
    // result stream
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    output logic [1:0]                           o_m_tuser,  // kind
    // byte_out[7:0], store_offset[39:8], status[41:40], char_count[73:42], zero
    output logic [lei_pkg::OUT_TDATA_W-1:0]      o_m_tdata,
    output logic                                 o_m_tlast,  // last
    // register port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [2:0]                           paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);

    // ------------------------------------------------------------------
    // Window registers. The user writes them only while the unit is idle
    // (not enforced), so the front end may use them directly in its address check.
    // ------------------------------------------------------------------
    logic [lei_pkg::DATA_W-1:0] r_window_start, r_window_end;
    logic                       reg_wr;

    assign pready = 1'b1;
    assign reg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_start <= lei_pkg::WINDOW_START_RST;
            r_window_end   <= lei_pkg::WINDOW_END_RST;
        end else if (reg_wr) begin
            if (paddr[2] == lei_pkg::REG_WINDOW_START) begin
                r_window_start <= pwdata;
            end else begin
                r_window_end <= pwdata;
            end
        end
    end

    assign prdata = (paddr[2] == lei_pkg::REG_WINDOW_END) ? r_window_end : r_window_start;

    // ------------------------------------------------------------------
    // Front: session state and classification. Each accepted item that
    // produces output becomes one command in the queue.
    // ------------------------------------------------------------------
    lei_pkg::t_cmd       push_cmd, head_cmd;
    lei_pkg::t_fifo_stat fifo_stat;
    logic                push, pop;

    lei_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_s_tvalid),
        .i_mode           (i_s_tuser),
        .i_descriptor     (i_s_tdata[7:0]),
        .i_buffer_address (i_s_tdata[39:8]),
        .i_length         (i_s_tdata[71:40]),
        .i_char_in        (i_s_tdata[79:72]),
        .i_window_start   (r_window_start),
        .i_window_end     (r_window_end),
        .i_fifo_stat      (fifo_stat),
        .o_ready          (o_s_tready),
        .o_push           (push),
        .o_cmd            (push_cmd)
    );

    // Queue decouples input acceptance from result back-pressure
    lei_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .i_pop   (pop),
        .o_data  (head_cmd),
        .o_stat  (fifo_stat)
    );

    // ------------------------------------------------------------------
    // Back: walks the head command one result per cycle, while the receiver
    // is ready, into the output register; the command is popped with its last result.
    // ------------------------------------------------------------------
    lei_pkg::t_kind             out_kind;
    lei_pkg::t_status           out_status;
    logic [7:0]                 out_byte;
    logic [lei_pkg::DATA_W-1:0] out_offset, out_count;

    lei_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (head_cmd),
        .i_fifo_stat (fifo_stat),
        .i_ready     (i_m_tready),
        .o_pop       (pop),
        .o_valid     (o_m_tvalid),
        .o_kind      (out_kind),
        .o_byte      (out_byte),
        .o_offset    (out_offset),
        .o_status    (out_status),
        .o_count     (out_count),
        .o_last      (o_m_tlast)
    );

    assign o_m_tuser = out_kind;
    assign o_m_tdata = {6'd0, out_count, out_status, out_offset, out_byte};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_ALWAYS(a_fifo_flags, i_clk, i_rst_n, !(fifo_stat.full && fifo_stat.empty), "queue both full and empty")
    `ASSERT_IMPL(a_finish_last, i_clk, i_rst_n, o_m_tvalid && (o_m_tuser == lei_pkg::KIND_FINISH), o_m_tlast, "finish result not marked last")
    `ASSERT_IMPL(a_echo_clean, i_clk, i_rst_n, o_m_tvalid && (o_m_tuser == lei_pkg::KIND_ECHO), o_m_tdata[73:8] == '0, "echo result carries offset, status or count")
    `ASSERT_IMPL(a_no_pop_empty, i_clk, i_rst_n, pop, !fifo_stat.empty, "pop from empty queue")

endmodule

// ===== tb/line_edit_input_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_edit_input_unit_tb
// Self-checking bench for the line edit input unit: read requests and typed
// characters go in on the slave stream, echo/store/finish transfers come back
// on the master stream and are checked against an in-bench line editor model.
// Both streams idle at random; the memory window is moved between phases.
// ----------------------------------------------------------------------------
module line_edit_input_unit_tb;

    localparam int RUN_LIMIT_NS  = 3_000_000;   // hard stop for the whole run
    localparam int DRAIN_LIMIT   = 2000;        // cycles allowed for results to come home
    localparam int SETTLE_CYCLES = 10;          // queue and output register lie between input and output; be generous
    localparam int HOLD_CYCLES   = 150;         // long receiver back-pressure burst

    // one input item: the mode and the fields of the slave tdata
    typedef struct packed {
        logic        mode;
        logic [7:0]  desc;
        logic [31:0] addr;
        logic [31:0] len;
        logic [7:0]  ch;
    } t_line_item;

    // one result transfer as the editor should produce it
    typedef struct packed {
        lei_pkg::t_kind   kind;
        logic [7:0]       data_byte;
        logic [31:0]      offset;
        lei_pkg::t_status status;
        logic [31:0]      count;
        logic             last;
    } t_edit_result;

    // directed row: item plus, where obvious, the single finish it must give
    typedef struct packed {
        t_line_item       item;
        logic             chk;
        lei_pkg::t_status st;
        logic [31:0]      cnt;
    } t_opening_row;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_s_tvalid;
    logic                              o_s_tready;
    logic                              i_s_tuser;
    logic [lei_pkg::IN_TDATA_W-1:0]    i_s_tdata;
    logic                              o_m_tvalid;
    logic                              i_m_tready;
    logic [1:0]                        o_m_tuser;
    logic [lei_pkg::OUT_TDATA_W-1:0]   o_m_tdata;
    logic                              o_m_tlast;
    logic                              psel;
    logic                              penable;
    logic                              pwrite;
    logic [2:0]                        paddr;
    logic [31:0]                       pwdata;
    logic [31:0]                       prdata;
    logic                              pready;

    line_edit_input_unit dut (.*);

    // ------------------------------------------------------------------
    // Editor model state (mirrors the block) and bench bookkeeping
    // ------------------------------------------------------------------
    logic [31:0]  win_lo;
    logic [31:0]  win_hi;
    logic         sess_open;
    logic [31:0]  fill_cnt;
    logic [31:0]  req_len;

    t_edit_result step_res [3];           // results of the item just transferred
    int           step_n;
    t_edit_result line_results_due [$];   // results owed by the block, oldest first

    int           mismatch_cnt = 0;
    bit           tx_fast = 1'b0;         // sender stretch with no gaps
    bit           rx_fast = 1'b0;         // receiver stretch with no stalls
    bit           hold_ask = 1'b0;        // asks the receiver for a long hold-off

    // Directed opening, default window 0xA000_0000 .. 0xA3FF_FFFF.
    // chk rows carry their one finish result typed in; the rest use the model.
    t_opening_row opening_rows [25] = '{
        // character with no session open: dropped, unused fields garbage
        '{'{lei_pkg::MODE_CHAR, 8'hFF, 32'hDEAD_BEEF, 32'hFFFF_FFFF, 8'h71},
          1'b0, lei_pkg::ST_OK, 32'd0},
        // descriptor all ones
        '{'{lei_pkg::MODE_REQUEST, 8'hFF, 32'hA000_0000, 32'd1, 8'hFF},
          1'b1, lei_pkg::ST_BAD_DESC, 32'd0},
        // bad descriptor wins over bad address
        '{'{lei_pkg::MODE_REQUEST, 8'h01, 32'h0000_0000, 32'd0, 8'h00},
          1'b1, lei_pkg::ST_BAD_DESC, 32'd0},
        // just below the window
        '{'{lei_pkg::MODE_REQUEST, 8'h00, 32'h9FFF_FFFF, 32'd1, 8'h00},
          1'b1, lei_pkg::ST_BAD_ADDR, 32'd0},
        // end address past 2^32: no wrap allowed
        '{'{lei_pkg::MODE_REQUEST, 8'h00, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h00},
          1'b1, lei_pkg::ST_BAD_ADDR, 32'd0},
        // one byte past the window end
        '{'{lei_pkg::MODE_REQUEST, 8'h00, 32'hA3FF_FFFF, 32'd2, 8'h00},
          1'b1, lei_pkg::ST_BAD_ADDR, 32'd0},
        // zero length skips the end check
        '{'{lei_pkg::MODE_REQUEST, 8'h00, 32'hFFFF_FFFF, 32'd0, 8'h00},
          1'b1, lei_pkg::ST_OK, 32'd0},
        // zero length still needs addr >= start
        '{'{lei_pkg::MODE_REQUEST, 8'h00, 32'h0000_0000, 32'd0, 8'h00},
          1'b1, lei_pkg::ST_BAD_ADDR, 32'd0},
        // last byte of window, length one, then one character fills it
        '{'{lei_pkg::MODE_REQUEST, 8'h00, 32'hA3FF_FFFF, 32'd1, 8'h00},
          1'b0, lei_pkg::ST_OK, 32'd0},
        '{'{lei_pkg::MODE_CHAR, 8'h00, 32'h0000_0000, 32'd0, 8'hFF},
          1'b0, lei_pkg::ST_OK, 32'd0},
        // whole window, EOT on an empty line
        '{'{lei_pkg::MODE_REQUEST, 8'h00, 32'hA000_0000, 32'h0400_0000, 8'h00},
          1'b0, lei_pkg::ST_OK, 32'd0},
        '{'{lei_pkg::MODE_CHAR, 8'h00, 32'h0000_0000, 32'd0, lei_pkg::CH_EOT},
          1'b1, lei_pkg::ST_OK, 32'd0},
        // erase on empty line does nothing, then type, erase and type again
        '{'{lei_pkg::MODE_REQUEST, 8'h00, 32'hA000_0000, 32'h0400_0000, 8'h00},
          1'b0, lei_pkg::ST_OK, 32'd0},
        '{'{lei_pkg::MODE_CHAR, 8'h00, 32'h0000_0000, 32'd0, lei_pkg::CH_BS},
          1'b0, lei_pkg::ST_OK, 32'd0},
        '{'{lei_pkg::MODE_CHAR, 8'h00, 32'h0000_0000, 32'd0, lei_pkg::CH_DEL},
          1'b0, lei_pkg::ST_OK, 32'd0},
        '{'{lei_pkg::MODE_CHAR, 8'h00, 32'h0000_0000, 32'd0, 8'h68},
          1'b0, lei_pkg::ST_OK, 32'd0},
        '{'{lei_pkg::MODE_CHAR, 8'h00, 32'h0000_0000, 32'd0, 8'h00},
          1'b0, lei_pkg::ST_OK, 32'd0},
        '{'{lei_pkg::MODE_CHAR, 8'h00, 32'h0000_0000, 32'd0, lei_pkg::CH_BS},
          1'b0, lei_pkg::ST_OK, 32'd0},
        '{'{lei_pkg::MODE_CHAR, 8'h00, 32'h0000_0000, 32'd0, lei_pkg::CH_DEL},
          1'b0, lei_pkg::ST_OK, 32'd0},
        '{'{lei_pkg::MODE_CHAR, 8'hA5, 32'h1234_5678, 32'h8000_0000, 8'h69},
          1'b0, lei_pkg::ST_OK, 32'd0},
        // new request drops the open session silently
        '{'{lei_pkg::MODE_REQUEST, 8'h00, 32'hA000_0010, 32'd3, 8'h7A},
          1'b0, lei_pkg::ST_OK, 32'd0},
        '{'{lei_pkg::MODE_CHAR, 8'h00, 32'h0000_0000, 32'd0, 8'h61},
          1'b0, lei_pkg::ST_OK, 32'd0},
        '{'{lei_pkg::MODE_CHAR, 8'h00, 32'h0000_0000, 32'd0, lei_pkg::CH_CR},
          1'b0, lei_pkg::ST_OK, 32'd0},
        // line feed on an empty line
        '{'{lei_pkg::MODE_REQUEST, 8'h00, 32'hA000_0000, 32'd10, 8'h00},
          1'b0, lei_pkg::ST_OK, 32'd0},
        '{'{lei_pkg::MODE_CHAR, 8'h00, 32'h0000_0000, 32'd0, lei_pkg::CH_LF},
          1'b0, lei_pkg::ST_OK, 32'd0}
    };

    // ------------------------------------------------------------------
    // Clock and run limit
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("line_edit_input_unit_tb: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // Line editor model
    // ------------------------------------------------------------------
    function automatic void add_result(lei_pkg::t_kind k, logic [7:0] b, logic [31:0] off,
                                       lei_pkg::t_status st, logic [31:0] cnt);
        step_res[step_n] = '{k, b, off, st, cnt, 1'b0};
        step_n++;
    endfunction

    // Works out the results of one item into step_res; returns 1 when the
    // item is a character with no session, i.e. dropped by the block.
    function automatic bit edit_line(t_line_item it);
        step_n = 0;
        if (it.mode == lei_pkg::MODE_REQUEST) begin
            sess_open = 1'b0;
            fill_cnt  = '0;
            req_len   = it.len;
            if (it.desc != 8'd0) begin
                add_result(lei_pkg::KIND_FINISH, 8'd0, '0, lei_pkg::ST_BAD_DESC, '0);
            end else if (it.addr < win_lo ||
                         (it.len != 0 &&
                          64'(it.addr) + 64'(it.len) - 64'd1 > 64'(win_hi))) begin
                add_result(lei_pkg::KIND_FINISH, 8'd0, '0, lei_pkg::ST_BAD_ADDR, '0);
            end else if (it.len == 0) begin
                add_result(lei_pkg::KIND_FINISH, 8'd0, '0, lei_pkg::ST_OK, '0);
            end else begin
                sess_open = 1'b1;
            end
        end else if (!sess_open) begin
            return 1'b1;
        end else if (it.ch == lei_pkg::CH_EOT) begin
            add_result(lei_pkg::KIND_FINISH, 8'd0, '0, lei_pkg::ST_OK, fill_cnt);
            sess_open = 1'b0;
        end else if (it.ch == lei_pkg::CH_BS || it.ch == lei_pkg::CH_DEL) begin
            // rub-out: nothing to erase on an empty line
            if (fill_cnt != 0) begin
                fill_cnt = fill_cnt - 1;
                add_result(lei_pkg::KIND_ECHO, lei_pkg::CH_BS, '0, lei_pkg::ST_OK, '0);
                add_result(lei_pkg::KIND_ECHO, lei_pkg::CH_SPACE, '0, lei_pkg::ST_OK, '0);
                add_result(lei_pkg::KIND_ECHO, lei_pkg::CH_BS, '0, lei_pkg::ST_OK, '0);
            end
        end else if (it.ch == lei_pkg::CH_LF || it.ch == lei_pkg::CH_CR) begin
            // newline is stored but not counted
            add_result(lei_pkg::KIND_STORE, lei_pkg::CH_LF, fill_cnt, lei_pkg::ST_OK, '0);
            add_result(lei_pkg::KIND_ECHO, lei_pkg::CH_LF, '0, lei_pkg::ST_OK, '0);
            add_result(lei_pkg::KIND_FINISH, 8'd0, '0, lei_pkg::ST_OK, fill_cnt);
            sess_open = 1'b0;
        end else begin
            add_result(lei_pkg::KIND_ECHO, it.ch, '0, lei_pkg::ST_OK, '0);
            add_result(lei_pkg::KIND_STORE, it.ch, fill_cnt, lei_pkg::ST_OK, '0);
            fill_cnt = fill_cnt + 1;
            if (fill_cnt == req_len) begin
                add_result(lei_pkg::KIND_FINISH, 8'd0, '0, lei_pkg::ST_OK, fill_cnt);
                sess_open = 1'b0;
            end
        end
        if (step_n > 0)
            step_res[step_n-1].last = 1'b1;
        return 1'b0;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_cnt++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Register port: setup cycle, access cycle, bus idle after
    // ------------------------------------------------------------------
    task automatic apb_access(bit wr, logic idx, logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata    = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Block must be idle here; writes both bounds and reads them back.
    task automatic set_window(logic [31:0] lo, logic [31:0] hi);
        logic [31:0] rd;
        apb_access(1'b1, lei_pkg::REG_WINDOW_START, lo, rd);
        win_lo = lo;
        apb_access(1'b1, lei_pkg::REG_WINDOW_END, hi, rd);
        win_hi = hi;
        apb_access(1'b0, lei_pkg::REG_WINDOW_START, '0, rd);
        check_field("window_start", lo, rd);
        apb_access(1'b0, lei_pkg::REG_WINDOW_END, '0, rd);
        check_field("window_end", hi, rd);
    endtask

    // ------------------------------------------------------------------
    // Slave side: one item per call, random gap before it
    // ------------------------------------------------------------------
    task automatic send_item(t_line_item it, logic chk, lei_pkg::t_status st,
                             logic [31:0] cnt, output bit skipped);
        int gap;
        gap = tx_fast ? 0 : $urandom_range(0, 18);
        if ($urandom_range(0, 11) == 0)
            tx_fast = !tx_fast;
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= it.mode;
        i_s_tdata  <= {it.ch, it.len, it.addr, it.desc};
        do @(posedge i_clk); while (!o_s_tready);
        // transfer took place at this edge
        skipped = edit_line(it);
        if (chk) begin
            line_results_due.push_back('{lei_pkg::KIND_FINISH, 8'd0, 32'd0, st, cnt, 1'b1});
        end else begin
            for (int i = 0; i < step_n; i++)
                line_results_due.push_back(step_res[i]);
        end
    endtask

    // Stop offering and wait until the block owes nothing, then let it settle.
    task automatic settle();
        int n;
        i_s_tvalid <= 1'b0;
        n = 0;
        while (line_results_due.size() != 0 && n < DRAIN_LIMIT) begin
            @(posedge i_clk);
            n++;
        end
        if (line_results_due.size() != 0) begin
            $error("%0d expected results never arrived", line_results_due.size());
            mismatch_cnt++;
            line_results_due.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Mostly well-formed sessions with random typing, plus noise: bad
    // requests with random fields and stray characters.
    task automatic run_phase(int n_items, int pause_at);
        t_line_item  it;
        int          done;
        int          n_chars;
        int          r;
        bit          skipped;
        logic [31:0] span;
        logic [31:0] room;
        done = 0;
        while (done < n_items) begin
            if (pause_at != 0 && done >= pause_at) begin
                settle();
                pause_at = 0;
            end
            r = $urandom_range(0, 9);
            if (r < 7) begin
                it.mode = lei_pkg::MODE_REQUEST;
                it.desc = 8'd0;
                it.ch   = 8'($urandom);
                r = $urandom_range(0, 19);
                if (r == 0)
                    it.len = 32'd0;
                else if (r < 4)
                    it.len = $urandom;
                else
                    it.len = $urandom_range(1, 12);
                // place the buffer inside the window where there is one
                if (win_hi >= win_lo) begin
                    span = win_hi - win_lo;
                    if (it.len != 0 && it.len - 1 > span)
                        it.len = span + 1;
                    room = (it.len == 0) ? span : span - (it.len - 1);
                    it.addr = win_lo + $urandom_range(0, room);
                end else begin
                    it.addr = $urandom;
                end
                send_item(it, 1'b0, lei_pkg::ST_OK, '0, skipped);
                done++;
                n_chars = $urandom_range(1, 16);
                while (sess_open && n_chars > 0) begin
                    it.mode = lei_pkg::MODE_CHAR;
                    it.desc = 8'($urandom);
                    it.addr = $urandom;
                    it.len  = $urandom;
                    r = $urandom_range(0, 39);
                    if (n_chars == 1) begin
                        // end of line: CR, LF, EOT or leave the session hanging
                        r = $urandom_range(0, 3);
                        it.ch = (r == 0) ? lei_pkg::CH_CR : (r == 1) ? lei_pkg::CH_LF :
                                (r == 2) ? lei_pkg::CH_EOT : 8'($urandom_range(32, 126));
                    end else if (r < 3) begin
                        it.ch = lei_pkg::CH_BS;
                    end else if (r < 5) begin
                        it.ch = lei_pkg::CH_DEL;
                    end else if (r < 8) begin
                        it.ch = 8'($urandom);
                    end else begin
                        it.ch = 8'($urandom_range(32, 126));
                    end
                    send_item(it, 1'b0, lei_pkg::ST_OK, '0, skipped);
                    if (!skipped)
                        done++;
                    n_chars--;
                end
            end else begin
                it.mode = (r == 9) ? lei_pkg::MODE_CHAR : lei_pkg::MODE_REQUEST;
                it.desc = ($urandom_range(0, 1) == 0) ? 8'($urandom) : 8'd0;
                it.addr = $urandom;
                it.len  = $urandom;
                it.ch   = 8'($urandom);
                send_item(it, 1'b0, lei_pkg::ST_OK, '0, skipped);
                if (!skipped)
                    done++;
            end
        end
        settle();
    endtask

    // ------------------------------------------------------------------
    // Master side: random stalls, long hold on request, result checking
    // ------------------------------------------------------------------
    initial begin : result_monitor
        int           wait_left;
        int           hold_left;
        t_edit_result want;
        wait_left  = 0;
        hold_left  = 0;
        i_m_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready) begin
                if (line_results_due.size() == 0) begin
                    $error("result with none expected: kind %0d, tdata 0x%0h",
                           o_m_tuser, o_m_tdata);
                    mismatch_cnt++;
                end else begin
                    want = line_results_due.pop_front();
                    check_field("kind",         want.kind,      o_m_tuser);
                    check_field("byte_out",     want.data_byte, o_m_tdata[7:0]);
                    check_field("store_offset", want.offset,    o_m_tdata[39:8]);
                    check_field("status",       want.status,    o_m_tdata[41:40]);
                    check_field("char_count",   want.count,     o_m_tdata[73:42]);
                    check_field("last",         want.last,      o_m_tlast);
                    check_field("tdata pad",    '0,             o_m_tdata[79:74]);
                end
                wait_left = rx_fast ? 0 : $urandom_range(0, 18);
                if ($urandom_range(0, 15) == 0)
                    rx_fast = !rx_fast;
            end
            if (hold_ask) begin
                hold_left = HOLD_CYCLES;
                hold_ask  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else if (wait_left > 0) begin
                wait_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic [31:0] rd;
        logic [31:0] lo_pick;
        logic [31:0] hi_pick;
        bit          skipped;

        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tuser  = 1'b0;
        i_s_tdata  = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        win_lo     = lei_pkg::WINDOW_START_RST;
        win_hi     = lei_pkg::WINDOW_END_RST;
        sess_open  = 1'b0;
        fill_cnt   = '0;
        req_len    = '0;
        step_n     = 0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // window registers come out of reset at their default range
        apb_access(1'b0, lei_pkg::REG_WINDOW_START, '0, rd);
        check_field("window_start", lei_pkg::WINDOW_START_RST, rd);
        apb_access(1'b0, lei_pkg::REG_WINDOW_END, '0, rd);
        check_field("window_end", lei_pkg::WINDOW_END_RST, rd);

        foreach (opening_rows[i])
            send_item(opening_rows[i].item, opening_rows[i].chk, opening_rows[i].st,
                      opening_rows[i].cnt, skipped);
        settle();

        // whole address space; receiver holds off so the input side backs up
        set_window(32'h0000_0000, 32'hFFFF_FFFF);
        hold_ask = 1'b1;
        run_phase(58, 0);

        // window at the very top; sender pauses mid-phase until drained
        set_window(32'hFFFF_FF00, 32'hFFFF_FFFF);
        run_phase(58, 30);

        // tiny window at address zero
        set_window(32'h0000_0000, 32'h0000_003F);
        run_phase(58, 0);

        // random window, end 16 to 4096 bytes above start
        lo_pick = $urandom;
        hi_pick = lo_pick + $urandom_range(16, 4096);
        if (hi_pick < lo_pick)
            hi_pick = 32'hFFFF_FFFF;
        set_window(lo_pick, hi_pick);
        run_phase(58, 0);

        // start above end: only zero-length requests can pass
        set_window(32'h8000_0000, 32'h7FFF_FFFF);
        run_phase(20, 0);

        if (mismatch_cnt == 0)
            $display("line_edit_input_unit_tb: done, clean");
        else
            $display("line_edit_input_unit_tb: done, errors");
        $finish;
    end

endmodule
